[hw/rtl/axis_angle_to_rotation_matrix_macros.svh]
// Assertion macros shared by the axis-angle to rotation matrix RTL
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/aa_pkg.sv]
// Types, constants and arithmetic helpers for the axis-angle to rotation matrix block
`timescale 1ns / 1ps

package aa_pkg;

    localparam int AA_ATAN_LEN   = 24;
    localparam int AA_SQRT_STEPS = 30;
    localparam int AA_DIV_STEPS  = 31;

    localparam logic signed [34:0] AA_PI      = 35'sd3373259426;
    localparam logic signed [34:0] AA_HALF_PI = 35'sd1686629713;
    localparam logic signed [34:0] AA_TWO_PI  = 35'sd6746518852;
    localparam logic signed [34:0] AA_ONE     = 35'sd1073741824;
    localparam logic signed [33:0] AA_CORDIC_K = 34'sd652032874;
    localparam logic [30:0]        AA_U_MAX    = 31'd1073741824;
    localparam logic signed [35:0] AA_ONE_W    = 36'sd1073741824;
    localparam logic signed [15:0] AA_Q14_ONE  = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        len2;
        logic               zero;
    } aa_axis_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg_cos;
        aa_axis_t           axis;
    } aa_cordic_t;

    typedef struct packed {
        logic [60:0]        n;
        logic [60:0]        res;
        logic signed [31:0] sth;
        logic signed [32:0] vth;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               zero;
    } aa_sqrt_t;

    typedef struct packed {
        logic [2:0][60:0]   rem;
        logic [2:0][30:0]   q;
        logic [2:0]         neg;
        logic [29:0]        s;
        logic signed [31:0] sth;
        logic signed [32:0] vth;
        logic               zero;
    } aa_div_t;

    function automatic logic signed [33:0] aa_atan(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Q30 product, round half up, floor shift
    function automatic logic signed [32:0] aa_mulq30(input logic signed [32:0] a,
                                                     input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [65:0] r;
        p = a * b;
        r = (p + 66'sd536870912) >>> 30;
        return r[32:0];
    endfunction

    // Q30 to Q1.14 with saturation to plus or minus one
    function automatic logic signed [15:0] aa_to_q14(input logic signed [35:0] v);
        logic signed [35:0] r;
        logic signed [15:0] o;
        r = (v + 36'sd32768) >>> 16;
        if (r > 36'sd16384)
            o = 16'sd16384;
        else if (r < -36'sd16384)
            o = -16'sd16384;
        else
            o = r[15:0];
        return o;
    endfunction

endpackage

[hw/rtl/aa_cordic_cell.sv]
// One rotation-mode CORDIC step with its pipeline register
`timescale 1ns / 1ps

module aa_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  aa_pkg::aa_cordic_t in_data,
    output logic               out_valid,
    output aa_pkg::aa_cordic_t out_data
);
    import aa_pkg::*;

    localparam logic signed [33:0] ATAN = aa_atan(STEP);

    aa_cordic_t         data_reg;
    aa_cordic_t         data_next;
    logic               valid_reg;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb
    begin
        data_next = in_data;
        dx        = in_data.y >>> STEP;
        dy        = in_data.x >>> STEP;
        if (!in_data.z[33])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/aa_sqrt_cell.sv]
// One digit of the bitwise integer square root with its pipeline register
`timescale 1ns / 1ps

module aa_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  aa_pkg::aa_sqrt_t in_data,
    output logic             out_valid,
    output aa_pkg::aa_sqrt_t out_data
);
    import aa_pkg::*;

    localparam logic [60:0] BIT = 61'(1) << (2 * STEP);

    aa_sqrt_t    data_reg;
    aa_sqrt_t    data_next;
    logic        valid_reg;
    logic [60:0] trial;

    always_comb
    begin
        data_next = in_data;
        trial     = in_data.res + BIT;
        if (in_data.n >= trial)
        begin
            data_next.n   = in_data.n - trial;
            data_next.res = (in_data.res >> 1) + BIT;
        end
        else
        begin
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/aa_div_cell.sv]
// One quotient bit of the three restoring dividers with its pipeline register
`timescale 1ns / 1ps

module aa_div_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  aa_pkg::aa_div_t in_data,
    output logic            out_valid,
    output aa_pkg::aa_div_t out_data
);
    import aa_pkg::*;

    aa_div_t     data_reg;
    aa_div_t     data_next;
    logic        valid_reg;
    logic [60:0] d;

    always_comb
    begin
        data_next = in_data;
        d         = 61'(in_data.s) << STEP;
        for (int k = 0; k < 3; k++)
        begin
            if (in_data.rem[k] >= d)
            begin
                data_next.rem[k]    = in_data.rem[k] - d;
                data_next.q[k][STEP] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/axis_angle_to_rotation_matrix.sv]
// Top level: axis-angle to 3x3 rotation matrix pipeline
`timescale 1ns / 1ps
`include "axis_angle_to_rotation_matrix_macros.svh"

// Fully pipelined; one transaction is accepted every cycle unless the output stalls, and results leave in order.
// The stages are two angle-reduction stages, one CORDIC cell per iteration (TRIG_ITERATIONS, held to 1..24),
// 30 square-root cells, 31 divider cells and three multiply/round stages. The whole row advances together
// whenever the output register is empty or being read, so a stall at the output holds every stage in place.
// A zero axis returns the identity with zero_axis set.
module axis_angle_to_rotation_matrix #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic               zero_axis
);
    import aa_pkg::*;

    localparam int ITERS = (TRIG_ITERATIONS > AA_ATAN_LEN) ? AA_ATAN_LEN :
                           (TRIG_ITERATIONS < 1) ? 1 : TRIG_ITERATIONS;

    logic en;

    // angle reduction and squares
    logic signed [34:0] th_full;
    logic signed [34:0] th_red;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;

    logic               p1_valid_reg;
    logic signed [33:0] p1_th_reg;
    logic [2:0][30:0]   p1_sq_reg;
    logic signed [15:0] p1_ax_reg;
    logic signed [15:0] p1_ay_reg;
    logic signed [15:0] p1_az_reg;
    logic               p1_zero_reg;

    logic signed [34:0] tr;
    aa_cordic_t         p2_next;
    aa_cordic_t         p2_reg;
    logic               p2_valid_reg;

    aa_cordic_t cor_data  [0:ITERS];
    logic       cor_valid [0:ITERS];

    logic signed [33:0] cth;
    logic signed [34:0] vth_w;
    aa_sqrt_t           sq_data  [0:AA_SQRT_STEPS];
    logic               sq_valid [0:AA_SQRT_STEPS];

    aa_div_t            dv_data  [0:AA_DIV_STEPS];
    logic               dv_valid [0:AA_DIV_STEPS];
    logic signed [15:0] comp     [0:2];
    logic [15:0]        mag      [0:2];
    logic [29:0]        root;

    logic [30:0]        qc [0:2];
    logic signed [32:0] u  [0:2];
    logic signed [32:0] sth_w;

    logic               m1_valid_reg;
    logic signed [32:0] m1_xx_reg, m1_yy_reg, m1_zz_reg;
    logic signed [32:0] m1_xy_reg, m1_yz_reg, m1_zx_reg;
    logic signed [32:0] m1_sx_reg, m1_sy_reg, m1_sz_reg;
    logic signed [32:0] m1_vth_reg;
    logic               m1_zero_reg;

    logic               m2_valid_reg;
    logic signed [32:0] m2_xx_reg, m2_yy_reg, m2_zz_reg;
    logic signed [32:0] m2_xy_reg, m2_yz_reg, m2_zx_reg;
    logic signed [32:0] m2_sx_reg, m2_sy_reg, m2_sz_reg;
    logic               m2_zero_reg;

    logic signed [35:0] e        [0:8];
    logic signed [15:0] mat_next [0:8];
    logic signed [15:0] mat_reg  [0:8];
    logic               zero_reg;
    logic               out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: one wrap by 2*pi, squares of the axis
    always_comb
    begin
        th_full = signed'({angle[15], angle, 18'd0});
        if (th_full > AA_PI)
            th_red = th_full - AA_TWO_PI;
        else if (th_full < -AA_PI)
            th_red = th_full + AA_TWO_PI;
        else
            th_red = th_full;
        sq_x = axis_x * axis_x;
        sq_y = axis_y * axis_y;
        sq_z = axis_z * axis_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= in_valid;
            p2_valid_reg  <= p1_valid_reg;
            m1_valid_reg  <= dv_valid[AA_DIV_STEPS];
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_th_reg    <= th_red[33:0];
            p1_sq_reg[0] <= sq_x[30:0];
            p1_sq_reg[1] <= sq_y[30:0];
            p1_sq_reg[2] <= sq_z[30:0];
            p1_ax_reg    <= axis_x;
            p1_ay_reg    <= axis_y;
            p1_az_reg    <= axis_z;
            p1_zero_reg  <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
        end
    end

    // stage 2: fold into [-pi/2, pi/2], axis length squared
    always_comb
    begin
        tr              = 35'(p1_th_reg);
        p2_next.x       = AA_CORDIC_K;
        p2_next.y       = 34'sd0;
        p2_next.neg_cos = 1'b0;
        p2_next.z       = p1_th_reg;
        if (tr > AA_HALF_PI)
        begin
            p2_next.z       = 34'(AA_PI - tr);
            p2_next.neg_cos = 1'b1;
        end
        else if (tr < -AA_HALF_PI)
        begin
            p2_next.z       = 34'(-AA_PI - tr);
            p2_next.neg_cos = 1'b1;
        end
        p2_next.axis.ax   = p1_ax_reg;
        p2_next.axis.ay   = p1_ay_reg;
        p2_next.axis.az   = p1_az_reg;
        p2_next.axis.len2 = 32'(p1_sq_reg[0]) + 32'(p1_sq_reg[1]) + 32'(p1_sq_reg[2]);
        p2_next.axis.zero = p1_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p2_reg <= p2_next;
    end

    assign cor_data[0]  = p2_reg;
    assign cor_valid[0] = p2_valid_reg;

    for (genvar g = 0; g < ITERS; g++)
    begin : g_cordic
        aa_cordic_cell #(.STEP(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cor_valid[g]),
            .in_data   (cor_data[g]),
            .out_valid (cor_valid[g+1]),
            .out_data  (cor_data[g+1])
        );
    end

    // sine, one minus cosine, radicand
    always_comb
    begin
        cth              = cor_data[ITERS].neg_cos ? -cor_data[ITERS].x : cor_data[ITERS].x;
        vth_w            = AA_ONE - 35'(cth);
        sq_data[0].n     = 61'({cor_data[ITERS].axis.len2, 28'd0});
        sq_data[0].res   = '0;
        sq_data[0].sth   = cor_data[ITERS].y[31:0];
        sq_data[0].vth   = vth_w[32:0];
        sq_data[0].ax    = cor_data[ITERS].axis.ax;
        sq_data[0].ay    = cor_data[ITERS].axis.ay;
        sq_data[0].az    = cor_data[ITERS].axis.az;
        sq_data[0].zero  = cor_data[ITERS].axis.zero;
    end

    assign sq_valid[0] = cor_valid[ITERS];

    for (genvar g = 0; g < AA_SQRT_STEPS; g++)
    begin : g_sqrt
        aa_sqrt_cell #(.STEP(AA_SQRT_STEPS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_data   (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_data  (sq_data[g+1])
        );
    end

    // rounded dividends for the three unit components
    always_comb
    begin
        root    = sq_data[AA_SQRT_STEPS].res[29:0];
        comp[0] = sq_data[AA_SQRT_STEPS].ax;
        comp[1] = sq_data[AA_SQRT_STEPS].ay;
        comp[2] = sq_data[AA_SQRT_STEPS].az;
        dv_data[0].q    = '0;
        dv_data[0].s    = root;
        dv_data[0].sth  = sq_data[AA_SQRT_STEPS].sth;
        dv_data[0].vth  = sq_data[AA_SQRT_STEPS].vth;
        dv_data[0].zero = sq_data[AA_SQRT_STEPS].zero;
        for (int k = 0; k < 3; k++)
        begin
            mag[k]            = comp[k][15] ? 16'(~comp[k] + 16'sd1) : comp[k];
            dv_data[0].neg[k] = comp[k][15];
            dv_data[0].rem[k] = 61'({mag[k], 44'd0}) + 61'(root >> 1);
        end
    end

    assign dv_valid[0] = sq_valid[AA_SQRT_STEPS];

    for (genvar g = 0; g < AA_DIV_STEPS; g++)
    begin : g_div
        aa_div_cell #(.STEP(AA_DIV_STEPS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    // clamp and sign of the unit axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qc[k] = (dv_data[AA_DIV_STEPS].q[k] > AA_U_MAX) ? AA_U_MAX
                                                           : dv_data[AA_DIV_STEPS].q[k];
            u[k]  = dv_data[AA_DIV_STEPS].neg[k] ? 33'sd0 - signed'(33'(qc[k]))
                                                  : signed'(33'(qc[k]));
        end
        sth_w = 33'(dv_data[AA_DIV_STEPS].sth);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_xx_reg   <= aa_mulq30(u[0], u[0]);
            m1_yy_reg   <= aa_mulq30(u[1], u[1]);
            m1_zz_reg   <= aa_mulq30(u[2], u[2]);
            m1_xy_reg   <= aa_mulq30(u[0], u[1]);
            m1_yz_reg   <= aa_mulq30(u[1], u[2]);
            m1_zx_reg   <= aa_mulq30(u[2], u[0]);
            m1_sx_reg   <= aa_mulq30(u[0], sth_w);
            m1_sy_reg   <= aa_mulq30(u[1], sth_w);
            m1_sz_reg   <= aa_mulq30(u[2], sth_w);
            m1_vth_reg  <= dv_data[AA_DIV_STEPS].vth;
            m1_zero_reg <= dv_data[AA_DIV_STEPS].zero;

            m2_xx_reg   <= aa_mulq30(m1_xx_reg, m1_vth_reg);
            m2_yy_reg   <= aa_mulq30(m1_yy_reg, m1_vth_reg);
            m2_zz_reg   <= aa_mulq30(m1_zz_reg, m1_vth_reg);
            m2_xy_reg   <= aa_mulq30(m1_xy_reg, m1_vth_reg);
            m2_yz_reg   <= aa_mulq30(m1_yz_reg, m1_vth_reg);
            m2_zx_reg   <= aa_mulq30(m1_zx_reg, m1_vth_reg);
            m2_sx_reg   <= m1_sx_reg;
            m2_sy_reg   <= m1_sy_reg;
            m2_sz_reg   <= m1_sz_reg;
            m2_zero_reg <= m1_zero_reg;
        end
    end

    // Rodrigues sums, rounding and saturation
    always_comb
    begin
        e[0] = AA_ONE_W - 36'(m2_zz_reg) - 36'(m2_yy_reg);
        e[1] = 36'(m2_xy_reg) - 36'(m2_sz_reg);
        e[2] = 36'(m2_sy_reg) + 36'(m2_zx_reg);
        e[3] = 36'(m2_sz_reg) + 36'(m2_xy_reg);
        e[4] = AA_ONE_W - 36'(m2_zz_reg) - 36'(m2_xx_reg);
        e[5] = 36'(m2_yz_reg) - 36'(m2_sx_reg);
        e[6] = 36'(m2_zx_reg) - 36'(m2_sy_reg);
        e[7] = 36'(m2_sx_reg) + 36'(m2_yz_reg);
        e[8] = AA_ONE_W - 36'(m2_yy_reg) - 36'(m2_xx_reg);
        for (int i = 0; i < 9; i++)
        begin
            if (m2_zero_reg)
                mat_next[i] = (i % 4 == 0) ? AA_Q14_ONE : 16'sd0;
            else
                mat_next[i] = aa_to_q14(e[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                mat_reg[i] <= mat_next[i];
            zero_reg <= m2_zero_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign m00       = mat_reg[0];
    assign m01       = mat_reg[1];
    assign m02       = mat_reg[2];
    assign m10       = mat_reg[3];
    assign m11       = mat_reg[4];
    assign m12       = mat_reg[5];
    assign m20       = mat_reg[6];
    assign m21       = mat_reg[7];
    assign m22       = mat_reg[8];
    assign zero_axis = zero_reg;

    `AA_ASSERT_IMP(a_zero_identity, clk, rst_n, out_valid_reg && zero_reg, mat_reg[0] == AA_Q14_ONE && mat_reg[4] == AA_Q14_ONE && mat_reg[8] == AA_Q14_ONE && mat_reg[1] == 16'sd0, "zero axis transaction without identity")
    `AA_ASSERT_IMP(a_root_nonzero, clk, rst_n, sq_valid[AA_SQRT_STEPS] && !sq_data[AA_SQRT_STEPS].zero, sq_data[AA_SQRT_STEPS].res != '0, "zero root for a nonzero axis")
    `AA_ASSERT_IMP(a_entry_range, clk, rst_n, out_valid_reg, mat_reg[1] <= AA_Q14_ONE && mat_reg[1] >= -AA_Q14_ONE && mat_reg[5] <= AA_Q14_ONE && mat_reg[5] >= -AA_Q14_ONE, "matrix entry outside saturation range")
    `AA_ASSERT_NXT(a_stall_hold, clk, rst_n, m2_valid_reg && !en, m2_valid_reg, "pipeline transaction lost during stall")

endmodule
